// ===== rtl/ppt_pkg.sv =====
// Shared types and codes for the promotable priority table.
package ppt_pkg;

    // Field widths of the request and result payloads
    localparam int ID_W   = 6;
    localparam int DATA_W = 32;
    localparam int PRIO_W = 16;
    localparam int OP_W   = 3;
    localparam int STAT_W = 2;

    // Operation codes
    localparam logic [OP_W-1:0] OP_ADD     = 3'd0;
    localparam logic [OP_W-1:0] OP_PROMOTE = 3'd1;
    localparam logic [OP_W-1:0] OP_PEEK    = 3'd2;
    localparam logic [OP_W-1:0] OP_POP     = 3'd3;
    localparam logic [OP_W-1:0] OP_CHECK   = 3'd4;
    localparam logic [OP_W-1:0] OP_READ    = 3'd5;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd2;
    localparam logic [STAT_W-1:0] ST_BAD_ID = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [ID_W-1:0]   entry_id;
        logic [DATA_W-1:0] entry_data;
    } t_req;

    typedef struct packed {
        logic [ID_W-1:0]   result_id;
        logic [DATA_W-1:0] result_data;
        logic [PRIO_W-1:0] result_priority;
        logic              is_live;
        logic [STAT_W-1:0] status;
    } t_rsp;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;
        logic add;
        logic res_full;
        logic rd_id;
        logic res_bad;
        logic res_empty;
        logic res_zero;
        logic single;
        logic scan_start;
        logic scan_step;
        logic scan_end;
        logic load_out;
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            full;
        logic            id_ok;
        logic            empty;
        logic            scan_last;
        logic            out_free;
    } t_stat;

endpackage

// ===== rtl/promotable_priority_table.sv =====
// Top level of the promotable priority table: controller plus datapath.
//
// Usage: requests enter on i_req with i_req_valid; o_req_stall holds them
// off while one request is in work. Results leave on o_rsp with o_rsp_valid
// and are held until a cycle with i_rsp_stall low. One result per request.
// Operations: add, promote, peek max, pop max, check valid, read data.
// Path through the controller from acceptance to result valid:
//   add and unknown operations, and any immediate error: decode, done;
//   promote, check valid, read data on a used id: decode, read wait, done;
//   peek and pop: decode, scan, scan end, done; the scan covers N = ids handed out
//   so far (at most CAPACITY), read one entry per cycle from the single entry memory.
// A new request is taken in the cycle after its predecessor's result is
// registered, even while that result is still stalled; a stalled receiver
// blocks the next request only once its result is ready to be written.
// Reset (synchronous, active low) empties the table and restarts ids at 0;
// no memory clearing is needed, so requests are taken right after reset.
module promotable_priority_table #(
    parameter int CAPACITY       = 64,
    parameter int DATA_WIDTH     = 32,
    parameter int PRIORITY_WIDTH = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_stall,
    input  ppt_pkg::t_req i_req,
    output logic          o_rsp_valid,
    input  logic          i_rsp_stall,
    output ppt_pkg::t_rsp o_rsp
);

    ppt_pkg::t_cmd  cmd;
    ppt_pkg::t_stat stat;

    // Sequencer
    ppt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_req_stall (o_req_stall)
    );

    // Storage and compute
    ppt_datapath #(
        .CAPACITY       (CAPACITY),
        .DATA_WIDTH     (DATA_WIDTH),
        .PRIORITY_WIDTH (PRIORITY_WIDTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_stall (i_rsp_stall),
        .o_rsp       (o_rsp)
    );

endmodule

// ===== rtl/ppt_ram.sv =====
// Generic simple dual-port RAM with registered read data.
module ppt_ram #(
    parameter int WIDTH = 49,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/ppt_datapath.sv =====
// Datapath: entry memory, id counters, max scan and result registers.
module ppt_datapath #(
    parameter int CAPACITY       = 64,
    parameter int DATA_WIDTH     = 32,
    parameter int PRIORITY_WIDTH = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  ppt_pkg::t_req i_req,
    input  ppt_pkg::t_cmd i_cmd,
    output ppt_pkg::t_stat o_stat,
    output logic          o_rsp_valid,
    input  logic          i_rsp_stall,
    output ppt_pkg::t_rsp o_rsp
);

    localparam int AW  = $clog2(CAPACITY);
    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int DOW = ppt_pkg::DATA_W;
    localparam int POW = ppt_pkg::PRIO_W;
    localparam int IW  = ppt_pkg::ID_W;
    localparam int SW  = (DATA_WIDTH < DOW) ? DATA_WIDTH : DOW;
    localparam int PW  = PRIORITY_WIDTH;
    localparam int WW  = 1 + PW + SW;
    localparam int XW  = (IW > CW) ? IW : CW;

    ppt_pkg::t_req r_req, n_req;
    ppt_pkg::t_rsp r_res, n_res;
    ppt_pkg::t_rsp r_rsp, n_rsp;
    logic          r_rsp_valid, n_rsp_valid;
    logic [CW-1:0] r_next_free, n_next_free;
    logic [CW-1:0] r_live_count, n_live_count;
    logic [AW-1:0] r_scan, n_scan;
    logic          r_found, n_found;
    logic [AW-1:0] r_best_id, n_best_id;
    logic [PW-1:0] r_best_prio, n_best_prio;
    logic [SW-1:0] r_best_data, n_best_data;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [WW-1:0] ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [WW-1:0] ram_rdata;

    logic [SW-1:0] rd_data;
    logic [PW-1:0] rd_prio;
    logic [PW-1:0] prio_inc;
    logic          rd_dead;
    logic [AW-1:0] id_idx;
    logic          scan_take;
    logic          out_free;

    // Entry memory: {dead, priority, data}; entries at or above next_free are unused
    ppt_ram #(
        .WIDTH (WW),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Split the read word
    assign rd_data   = ram_rdata[SW-1:0];
    assign rd_prio   = ram_rdata[SW+PW-1:SW];
    assign rd_dead   = ram_rdata[WW-1];
    assign prio_inc  = (rd_prio == {PW{1'b1}}) ? rd_prio : rd_prio + PW'(1);
    assign id_idx    = AW'(r_req.entry_id);
    assign scan_take = !rd_dead && (!r_found || rd_prio >= r_best_prio);
    assign out_free  = !r_rsp_valid || !i_rsp_stall;

    // Report conditions to the controller
    always_comb begin
        o_stat.op        = r_req.operation;
        o_stat.full      = (r_next_free == CW'(CAPACITY));
        o_stat.id_ok     = (XW'(r_req.entry_id) < XW'(r_next_free));
        o_stat.empty     = (r_live_count == '0);
        o_stat.scan_last = ((CW'(r_scan) + CW'(1)) == r_next_free);
        o_stat.out_free  = out_free;
    end

    // Execute the controller's commands
    always_comb begin
        n_req        = r_req;
        n_res        = r_res;
        n_rsp        = r_rsp;
        n_rsp_valid  = r_rsp_valid;
        n_next_free  = r_next_free;
        n_live_count = r_live_count;
        n_scan       = r_scan;
        n_found      = r_found;
        n_best_id    = r_best_id;
        n_best_prio  = r_best_prio;
        n_best_data  = r_best_data;
        ram_we       = 1'b0;
        ram_waddr    = '0;
        ram_wdata    = '0;
        ram_re       = 1'b0;
        ram_raddr    = '0;

        // Latch the request
        if (i_cmd.capture) begin
            n_req = i_req;
        end

        // Add an entry at the next unused id
        if (i_cmd.add) begin
            ram_we              = 1'b1;
            ram_waddr           = AW'(r_next_free);
            ram_wdata           = {1'b0, {PW{1'b0}}, SW'(r_req.entry_data)};
            n_res               = '0;
            n_res.result_id     = IW'(r_next_free);
            n_next_free         = r_next_free + CW'(1);
            n_live_count        = r_live_count + CW'(1);
        end

        // Immediate outcomes
        if (i_cmd.res_full) begin
            n_res        = '0;
            n_res.status = ppt_pkg::ST_FULL;
        end
        if (i_cmd.res_bad) begin
            n_res = '0;
            if (r_req.operation != ppt_pkg::OP_CHECK) begin
                n_res.status = ppt_pkg::ST_BAD_ID;
            end
        end
        if (i_cmd.res_empty) begin
            n_res        = '0;
            n_res.status = ppt_pkg::ST_EMPTY;
        end
        if (i_cmd.res_zero) begin
            n_res = '0;
        end

        // Read one addressed entry
        if (i_cmd.rd_id) begin
            ram_re    = 1'b1;
            ram_raddr = id_idx;
        end

        // Finish an operation on one addressed entry
        if (i_cmd.single) begin
            n_res = '0;
            if (rd_dead) begin
                if (r_req.operation != ppt_pkg::OP_CHECK) begin
                    n_res.status = ppt_pkg::ST_BAD_ID;
                end
            end else if (r_req.operation == ppt_pkg::OP_PROMOTE) begin
                ram_we    = 1'b1;
                ram_waddr = id_idx;
                ram_wdata = {1'b0, prio_inc, rd_data};
            end else if (r_req.operation == ppt_pkg::OP_CHECK) begin
                n_res.is_live = 1'b1;
            end else begin
                n_res.result_data = DOW'(rd_data);
            end
        end

        // Start the max scan at entry zero
        if (i_cmd.scan_start) begin
            ram_re    = 1'b1;
            ram_raddr = '0;
            n_scan    = '0;
            n_found   = 1'b0;
        end

        // Compare one entry and fetch the next
        if (i_cmd.scan_step) begin
            ram_re    = 1'b1;
            ram_raddr = r_scan + AW'(1);
            n_scan    = r_scan + AW'(1);
            if (scan_take) begin
                n_found     = 1'b1;
                n_best_id   = r_scan;
                n_best_prio = rd_prio;
                n_best_data = rd_data;
            end
        end

        // Report the maximum; kill it on pop
        if (i_cmd.scan_end) begin
            n_res                 = '0;
            n_res.result_id       = IW'(r_best_id);
            n_res.result_data     = DOW'(r_best_data);
            n_res.result_priority = POW'(r_best_prio);
            if (r_req.operation == ppt_pkg::OP_POP) begin
                ram_we       = 1'b1;
                ram_waddr    = r_best_id;
                ram_wdata    = {1'b1, r_best_prio, r_best_data};
                n_live_count = r_live_count - CW'(1);
            end
        end

        // Output register
        if (i_cmd.load_out) begin
            n_rsp_valid = 1'b1;
            n_rsp       = r_res;
        end else if (!i_rsp_stall) begin
            n_rsp_valid = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid  <= 1'b0;
            r_next_free  <= '0;
            r_live_count <= '0;
            r_found      <= 1'b0;
        end else begin
            r_rsp_valid  <= n_rsp_valid;
            r_next_free  <= n_next_free;
            r_live_count <= n_live_count;
            r_found      <= n_found;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_req       <= n_req;
        r_res       <= n_res;
        r_rsp       <= n_rsp;
        r_scan      <= n_scan;
        r_best_id   <= n_best_id;
        r_best_prio <= n_best_prio;
        r_best_data <= n_best_data;
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

`ifndef SYNTHESIS
    a_live_le_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_live_count <= r_next_free)
        else $error("live count exceeds ids handed out");

    a_scan_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scan_end |-> r_found)
        else $error("max scan ended without a live entry");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> out_free)
        else $error("result loaded over an undelivered result");

    a_ids_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_next_free >= $past(r_next_free))
        else $error("next free id moved backward");
`endif

endmodule

// ===== rtl/ppt_ctrl.sv =====
// Controller state machine: sequences each request through the datapath.
module ppt_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    input  ppt_pkg::t_stat i_stat,
    output ppt_pkg::t_cmd  o_cmd,
    output logic           o_req_stall
);

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_DECODE  = 6'b000010,
        S_RDWAIT  = 6'b000100,
        S_SCAN    = 6'b001000,
        S_SCANEND = 6'b010000,
        S_DONE    = 6'b100000
    } t_state;

    t_state r_state, n_state;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_stat.op == ppt_pkg::OP_ADD) begin
                    o_cmd.add      = !i_stat.full;
                    o_cmd.res_full = i_stat.full;
                    n_state        = S_DONE;
                end else if (i_stat.op == ppt_pkg::OP_PROMOTE
                             || i_stat.op == ppt_pkg::OP_CHECK
                             || i_stat.op == ppt_pkg::OP_READ) begin
                    if (i_stat.id_ok) begin
                        o_cmd.rd_id = 1'b1;
                        n_state     = S_RDWAIT;
                    end else begin
                        o_cmd.res_bad = 1'b1;
                        n_state       = S_DONE;
                    end
                end else if (i_stat.op == ppt_pkg::OP_PEEK
                             || i_stat.op == ppt_pkg::OP_POP) begin
                    if (i_stat.empty) begin
                        o_cmd.res_empty = 1'b1;
                        n_state         = S_DONE;
                    end else begin
                        o_cmd.scan_start = 1'b1;
                        n_state          = S_SCAN;
                    end
                end else begin
                    o_cmd.res_zero = 1'b1;
                    n_state        = S_DONE;
                end
            end
            S_RDWAIT: begin
                o_cmd.single = 1'b1;
                n_state      = S_DONE;
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_stat.scan_last) begin
                    n_state = S_SCANEND;
                end
            end
            S_SCANEND: begin
                o_cmd.scan_end = 1'b1;
                n_state        = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_req_stall = (r_state != S_IDLE);

endmodule
